/* rtl/ljpt_pkg.sv */
// ----------------------------------------------------------------------------
// ljpt_pkg: shared definitions for the LFSR jittered position table
// Constants of the LFSR, register indexes, request codes and the result type.
// ----------------------------------------------------------------------------
package ljpt_pkg;

   localparam int unsigned LFSR_W      = 16;
   localparam int unsigned NUM_ELEMS   = 8;
   localparam int unsigned HALF_ELEMS  = NUM_ELEMS / 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hA5A5;
   localparam logic [LFSR_W-1:0] LFSR_POLY   = 16'h1D87;
   localparam int unsigned       LFSR_TAP    = 14;
   localparam logic [1:0]        JITTER_MASK = 2'd3;

   typedef enum logic [1:0] {
      REQ_STEP     = 2'd0,
      REQ_SELECTOR = 2'd1,
      REQ_DRAW     = 2'd2,
      REQ_UNKNOWN  = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE0_LOW  = 3'd0,
      CSR_BASE0_HIGH = 3'd1,
      CSR_BASE1_LOW  = 3'd2,
      CSR_BASE1_HIGH = 3'd3,
      CSR_OBJ_COUNT  = 3'd4
   } csr_index_type;

   typedef logic [NUM_ELEMS-1:0][LFSR_W-1:0] elem_vec_type;

   typedef struct packed {
      logic              object_valid;
      logic              object_index;
      elem_vec_type      pos;
      logic [LFSR_W-1:0] random_value;
   } result_type;

   // One LFSR draw. A zero state is replaced by the seed before shifting.
   function automatic logic [LFSR_W-1:0] lfsr_draw(input logic [LFSR_W-1:0] state);
      logic [LFSR_W-1:0] prior;
      prior = (state == '0) ? LFSR_SEED : state;
      return {prior[LFSR_W-2:0], 1'b0} ^ (prior[LFSR_TAP] ? LFSR_POLY : '0);
   endfunction

endpackage

/* rtl/lfsr_jittered_position_table_top.sv */
// ----------------------------------------------------------------------------
// lfsr_jittered_position_table_top: LFSR jittered position table
// Holds the LFSR and object pointer and answers every request (step, selector,
// draw or unknown) with one result transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Prefix  Direction  Handshake       Carries
//   request   req_    in         valid / ready   request kind, suppress bit
//   response  rsp_    out        valid / ready   object, eight positions, draw
//   config    csr_    in         write enable    base halfwords, object count
//
// A request transaction is captured in an input register, evaluated in one
// pass of combinational logic and written to the response register when it
// is free or being emptied. Throughput is one transaction per cycle unless
// the response stalls; the rate is set by the loop through the LFSR and
// pointer registers: up to nine chained draws per cycle. Reset clears the
// LFSR, pointer, base registers and valid flags; the block is ready once
// reset is released. A stalled response holds its register; the input
// register still takes one more transaction before the request ready drops.
//
module lfsr_jittered_position_table_top
   import ljpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic                   req_suppressed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_object_valid,
   output logic                   rsp_object_index,
   output logic signed [15:0]     rsp_pos0,
   output logic signed [15:0]     rsp_pos1,
   output logic signed [15:0]     rsp_pos2,
   output logic signed [15:0]     rsp_pos3,
   output logic signed [15:0]     rsp_pos4,
   output logic signed [15:0]     rsp_pos5,
   output logic signed [15:0]     rsp_pos6,
   output logic signed [15:0]     rsp_pos7,
   output logic [15:0]            rsp_random_value,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers: two 64-bit halves of four halfwords per object.
   logic [1:0][1:0][CSR_DATA_W-1:0]              base_ff;
   logic [1:0]                                   count_ff;
   logic [1:0][NUM_ELEMS-1:0][LFSR_W-1:0]        base_view;

   // Architectural state.
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic              ptr_ff, ptr_in;

   // Input register.
   logic              in_valid_ff;
   logic [1:0]        in_kind_ff;
   logic              in_supp_ff;

   // Response register.
   logic              out_valid_ff;
   result_type        out_ff, out_in;

   logic              advance;
   logic              capture;

   // The input register moves on whenever the response register is free
   // or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign capture   = req_valid && req_ready;

   always_comb begin
      for (int o = 0; o < 2; o++) begin
         for (int i = 0; i < NUM_ELEMS; i++) begin
            base_view[o][i] = base_ff[o][i / HALF_ELEMS][(i % HALF_ELEMS)*LFSR_W +: LFSR_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= 2'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE0_LOW:  base_ff[0][0] <= csr_wdata;
            CSR_BASE0_HIGH: base_ff[0][1] <= csr_wdata;
            CSR_BASE1_LOW:  base_ff[1][0] <= csr_wdata;
            CSR_BASE1_HIGH: base_ff[1][1] <= csr_wdata;
            CSR_OBJ_COUNT:  count_ff      <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   ljpt_engine u_engine (
      .req_kind     (in_kind_ff),
      .suppressed   (in_supp_ff),
      .lfsr_cur     (lfsr_ff),
      .obj_ptr_cur  (ptr_ff),
      .object_count (count_ff),
      .base         (base_view),
      .result       (out_in),
      .lfsr_next    (lfsr_in),
      .obj_ptr_next (ptr_in)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lfsr_ff      <= '0;
         ptr_ff       <= 1'b0;
      end else begin
         if (capture) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            lfsr_ff      <= lfsr_in;
            ptr_ff       <= ptr_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (capture) begin
         in_kind_ff <= req_type;
         in_supp_ff <= req_suppressed;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_object_valid = out_ff.object_valid;
   assign rsp_object_index = out_ff.object_index;
   assign rsp_pos0         = out_ff.pos[0];
   assign rsp_pos1         = out_ff.pos[1];
   assign rsp_pos2         = out_ff.pos[2];
   assign rsp_pos3         = out_ff.pos[3];
   assign rsp_pos4         = out_ff.pos[4];
   assign rsp_pos5         = out_ff.pos[5];
   assign rsp_pos6         = out_ff.pos[6];
   assign rsp_pos7         = out_ff.pos[7];
   assign rsp_random_value = out_ff.random_value;

   // A response that updated an object must have toggled the pointer.
   a_ptr_toggles: assert property (@(posedge clock) disable iff (reset)
      advance && out_in.object_valid |=> ptr_ff != $past(ptr_ff))
      else $error("object pointer did not toggle after an object update");

   // A response without an object carries zero index and positions.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.object_valid |->
         !out_ff.object_index && out_ff.pos == '0)
      else $error("empty response carries object data");

   // Object one is only reported when the count allows two objects.
   a_obj1_present: assert property (@(posedge clock) disable iff (reset)
      advance && out_in.object_valid && out_in.object_index |-> count_ff[1])
      else $error("absent object reported");

   // The LFSR only moves when a transaction passes to the response register.
   a_lfsr_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(lfsr_ff) && $stable(ptr_ff))
      else $error("state changed without a transaction");

endmodule

/* rtl/ljpt_engine.sv */
// ----------------------------------------------------------------------------
// ljpt_engine: single-pass request evaluation
// Works out the result and the next LFSR state and pointer for one request.
// ----------------------------------------------------------------------------
module ljpt_engine
   import ljpt_pkg::*;
(
   input  logic [1:0]                         req_kind,
   input  logic                               suppressed,
   input  logic [LFSR_W-1:0]                  lfsr_cur,
   input  logic                               obj_ptr_cur,
   input  logic [1:0]                         object_count,
   input  logic [1:0][NUM_ELEMS-1:0][LFSR_W-1:0] base,
   output result_type                         result,
   output logic [LFSR_W-1:0]                  lfsr_next,
   output logic                               obj_ptr_next
);

   logic [LFSR_W-1:0]                 pre_state;
   logic [NUM_ELEMS:0][LFSR_W-1:0]    chain;
   logic                              do_step;
   logic                              present;

   always_comb begin
      do_step   = 1'b0;
      pre_state = lfsr_cur;
      unique case (req_kind)
         REQ_STEP: begin
            do_step = 1'b1;
         end
         REQ_SELECTOR: begin
            pre_state = lfsr_draw(lfsr_cur);
            do_step   = !suppressed;
         end
         REQ_DRAW: begin
            pre_state = lfsr_draw(lfsr_cur);
         end
         default: begin
            do_step = 1'b0;
         end
      endcase

      // Object one exists only when the count reads two or more.
      present = !obj_ptr_cur || object_count[1];

      chain[0] = pre_state;
      for (int i = 0; i < NUM_ELEMS; i++) begin
         chain[i+1] = lfsr_draw(chain[i]);
      end

      result = '0;
      obj_ptr_next = do_step ? !obj_ptr_cur : obj_ptr_cur;
      if (do_step && present) begin
         result.object_valid = 1'b1;
         result.object_index = obj_ptr_cur;
         for (int i = 0; i < NUM_ELEMS; i++) begin
            result.pos[i] = base[obj_ptr_cur][i]
                          + {{(LFSR_W-2){1'b0}}, chain[i+1][1:0] & JITTER_MASK};
         end
         lfsr_next = chain[NUM_ELEMS];
      end else begin
         lfsr_next = pre_state;
      end
      result.random_value = lfsr_next;
   end

endmodule
